### sv/hunk_word_stream_parser_core_macros.svh
// Assertion macros for the hunk word stream parser.
// Used by the top level; depends on nothing else.
`ifndef HUNK_WORD_STREAM_PARSER_CORE_MACROS_SVH
`define HUNK_WORD_STREAM_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hws_pkg.sv
// Shared types and constants for the hunk word stream parser.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package hws_pkg;

    // Field widths of the two channels.
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 5;
    localparam int CODE_W  = 30;
    localparam int CLASS_W = 2;

    // Hunk type codes, after the memory class bits are removed.
    localparam logic [CODE_W-1:0] T_HEADER  = 30'h3f3;
    localparam logic [CODE_W-1:0] T_CODE    = 30'h3e9;
    localparam logic [CODE_W-1:0] T_RELOC32 = 30'h3ec;
    localparam logic [CODE_W-1:0] T_SYMBOL  = 30'h3f0;

    // The first word of a file must match this exactly.
    localparam logic [WORD_W-1:0] MAGIC_WORD = 32'h0000_03f3;

    // Memory class that announces a flags word.
    localparam logic [CLASS_W-1:0] CLASS_FLAGS = 2'd3;

    // Labels given to each word.
    typedef enum logic [KIND_W-1:0] {
        KIND_TYPE        = 5'd0,
        KIND_FLAGS       = 5'd1,
        KIND_HDR_NAME    = 5'd2,
        KIND_TABLE_LEN   = 5'd3,
        KIND_FIRST       = 5'd4,
        KIND_LAST        = 5'd5,
        KIND_SIZE        = 5'd6,
        KIND_CODE_LEN    = 5'd7,
        KIND_CODE        = 5'd8,
        KIND_RELOC_COUNT = 5'd9,
        KIND_RELOC_HUNK  = 5'd10,
        KIND_RELOC_OFF   = 5'd11,
        KIND_RELOC_END   = 5'd12,
        KIND_SYM_LEN     = 5'd13,
        KIND_SYM_NAME    = 5'd14,
        KIND_SYM_OFF     = 5'd15,
        KIND_IGNORED     = 5'd16,
        KIND_BAD_MAGIC   = 5'd17
    } kind_t;

    // Parser position within the file.
    typedef enum logic [4:0] {
        PH_MAGIC, PH_TYPE, PH_FLAGS, PH_HNLEN, PH_HNAME, PH_HTAB, PH_HFIRST,
        PH_HLAST, PH_HSIZE, PH_CLEN, PH_CODE, PH_RCOUNT, PH_RHUNK, PH_ROFF,
        PH_SLEN, PH_SNAME, PH_SOFF, PH_STOP
    } phase_t;

    // Body that follows a type word (and its flags word, if any).
    typedef enum logic [1:0] {
        BODY_NONE, BODY_CODE, BODY_RELOC, BODY_SYMBOL
    } body_t;

endpackage

### sv/hws_in_if.sv
// Input channel of the hunk word stream parser: one file word per request.
// Depends on hws_pkg for the field widths.
`timescale 1ns / 1ps

interface hws_in_if;
    logic                          valid;
    logic                          ready;
    logic [hws_pkg::WORD_W-1:0]    word;
    logic                          restart;

    modport source (output valid, output word, output restart, input ready);
    modport sink   (input valid, input word, input restart, output ready);
endinterface

### sv/hws_out_if.sv
// Output channel of the hunk word stream parser: one labeled word per request.
// Depends on hws_pkg for the field widths.
`timescale 1ns / 1ps

interface hws_out_if;
    logic                          valid;
    logic                          ready;
    logic [hws_pkg::KIND_W-1:0]    kind;
    logic [hws_pkg::WORD_W-1:0]    value;
    logic [hws_pkg::CODE_W-1:0]    type_code;
    logic [hws_pkg::CLASS_W-1:0]   memory_class;
    logic                          stopped;

    modport source (output valid, output kind, output value, output type_code,
                    output memory_class, output stopped, input ready);
    modport sink   (input valid, input kind, input value, input type_code,
                    input memory_class, input stopped, output ready);
endinterface

### sv/hunk_word_stream_parser_core.sv
// Hunk word stream parser: top level.
// Depends on hws_pkg, hws_in_if, hws_out_if and the assertion macro header.
//
// Usage:
// - words: one big-endian 32-bit word of a hunk executable per request;
//   restart set marks the first word of a new file and discards all state.
// - labels: one result per word, carrying the word's kind, the word itself,
//   and for type words the hunk code and memory class (zero for a header
//   type). stopped is set once parsing has ended on bad magic or an unhandled
//   hunk type; every later word is labeled ignored until a restart.
// - A word accepted at a clock edge shows on labels in the following cycle.
//   Throughput is one word per cycle while labels are not stalled; the phase,
//   remaining-count and pending-body registers update as each word is taken.
// - The single output register lets a new word in whenever that register is
//   empty or being emptied in the same cycle. While the receiver stalls a
//   full register, words.ready is low in that same cycle and the result is
//   held unchanged.
// - Reset clears the output valid flag and returns the parser to expecting
//   the magic header word.
`timescale 1ns / 1ps
`include "hunk_word_stream_parser_core_macros.svh"

module hunk_word_stream_parser_core (
    input  logic      clk,
    input  logic      rst_n,
    hws_in_if.sink    words,
    hws_out_if.source labels
);
    import hws_pkg::*;

    // Parser state
    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   remaining_reg, remaining_next;
    body_t               pending_reg, pending_next;

    // Result register
    logic                out_vld_reg;
    kind_t               kind_reg, kind_next;
    logic [WORD_W-1:0]   value_reg;
    logic [CODE_W-1:0]   hcode_reg, hcode_next;
    logic [CLASS_W-1:0]  mclass_reg, mclass_next;
    logic                stopped_reg;

    // State seen by this word after a possible restart
    phase_t              ph;
    logic [WORD_W-1:0]   rem;
    logic [WORD_W-1:0]   rem_dec;
    body_t               pend;
    logic [CODE_W-1:0]   word_code;
    logic [CLASS_W-1:0]  word_class;
    body_t               word_body;
    logic                in_fire;

    // Phase entered once a non-header type (and its flags) has been taken.
    function automatic phase_t enter_body(input body_t body);
        phase_t p;
        case (body)
            BODY_CODE:   p = PH_CLEN;
            BODY_RELOC:  p = PH_RCOUNT;
            BODY_SYMBOL: p = PH_SLEN;
            default:     p = PH_STOP;
        endcase
        return p;
    endfunction

    // Handshake: take a word whenever the result register is free.
    assign words.ready = !out_vld_reg || labels.ready;
    assign in_fire     = words.valid && words.ready;

    // Split the incoming word.
    assign word_code  = words.word[CODE_W-1:0];
    assign word_class = words.word[WORD_W-1:CODE_W];
    always_comb
    begin
        if (word_code == T_CODE)
            word_body = BODY_CODE;
        else if (word_code == T_RELOC32)
            word_body = BODY_RELOC;
        else if (word_code == T_SYMBOL)
            word_body = BODY_SYMBOL;
        else
            word_body = BODY_NONE;
    end

    // Restart discards the stored state for this word.
    assign ph      = words.restart ? PH_MAGIC : phase_reg;
    assign rem     = words.restart ? '0 : remaining_reg;
    assign pend    = words.restart ? BODY_NONE : pending_reg;
    assign rem_dec = rem - WORD_W'(1);

    // Next state and label for the incoming word.
    always_comb
    begin
        kind_next      = KIND_IGNORED;
        hcode_next     = '0;
        mclass_next    = '0;
        phase_next     = ph;
        remaining_next = rem;
        pending_next   = pend;
        case (ph)
            PH_MAGIC, PH_TYPE:
            begin
                if (ph == PH_MAGIC && words.word != MAGIC_WORD)
                begin
                    kind_next  = KIND_BAD_MAGIC;
                    phase_next = PH_STOP;
                end
                else
                begin
                    kind_next  = KIND_TYPE;
                    hcode_next = word_code;
                    if (word_code == T_HEADER)
                        phase_next = PH_HNLEN;
                    else
                    begin
                        mclass_next = word_class;
                        if (word_class == CLASS_FLAGS)
                        begin
                            pending_next = word_body;
                            phase_next   = PH_FLAGS;
                        end
                        else
                            phase_next = enter_body(word_body);
                    end
                end
            end
            PH_FLAGS:
            begin
                kind_next    = KIND_FLAGS;
                phase_next   = enter_body(pend);
                pending_next = BODY_NONE;
            end
            PH_HNLEN:
            begin
                kind_next      = KIND_HDR_NAME;
                remaining_next = words.word;
                phase_next     = (words.word != '0) ? PH_HNAME : PH_HTAB;
            end
            PH_HNAME:
            begin
                kind_next      = KIND_HDR_NAME;
                remaining_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_HTAB;
            end
            PH_HTAB:
            begin
                kind_next      = KIND_TABLE_LEN;
                remaining_next = words.word;
                phase_next     = PH_HFIRST;
            end
            PH_HFIRST:
            begin
                kind_next  = KIND_FIRST;
                phase_next = PH_HLAST;
            end
            PH_HLAST:
            begin
                kind_next  = KIND_LAST;
                phase_next = (rem != '0) ? PH_HSIZE : PH_TYPE;
            end
            PH_HSIZE:
            begin
                kind_next      = KIND_SIZE;
                remaining_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_TYPE;
            end
            PH_CLEN:
            begin
                kind_next      = KIND_CODE_LEN;
                remaining_next = words.word;
                phase_next     = (words.word != '0) ? PH_CODE : PH_TYPE;
            end
            PH_CODE:
            begin
                kind_next      = KIND_CODE;
                remaining_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_TYPE;
            end
            PH_RCOUNT:
            begin
                if (words.word == '0)
                begin
                    kind_next  = KIND_RELOC_END;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    kind_next      = KIND_RELOC_COUNT;
                    remaining_next = words.word;
                    phase_next     = PH_RHUNK;
                end
            end
            PH_RHUNK:
            begin
                kind_next  = KIND_RELOC_HUNK;
                phase_next = PH_ROFF;
            end
            PH_ROFF:
            begin
                kind_next      = KIND_RELOC_OFF;
                remaining_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_RCOUNT;
            end
            PH_SLEN:
            begin
                kind_next = KIND_SYM_LEN;
                if (words.word == '0)
                    phase_next = PH_TYPE;
                else
                begin
                    remaining_next = words.word;
                    phase_next     = PH_SNAME;
                end
            end
            PH_SNAME:
            begin
                kind_next      = KIND_SYM_NAME;
                remaining_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_SOFF;
            end
            PH_SOFF:
            begin
                kind_next  = KIND_SYM_OFF;
                phase_next = PH_SLEN;
            end
            default:
            begin
                kind_next  = KIND_IGNORED;
                phase_next = PH_STOP;
            end
        endcase
    end

    // Parser state registers, advanced once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            remaining_reg <= '0;
            pending_reg   <= BODY_NONE;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            pending_reg   <= pending_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (in_fire)
            out_vld_reg <= 1'b1;
        else if (labels.ready)
            out_vld_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg    <= kind_next;
            value_reg   <= words.word;
            hcode_reg   <= hcode_next;
            mclass_reg  <= mclass_next;
            stopped_reg <= (phase_next == PH_STOP);
        end
    end

    assign labels.valid        = out_vld_reg;
    assign labels.kind         = kind_reg;
    assign labels.value        = value_reg;
    assign labels.type_code    = hcode_reg;
    assign labels.memory_class = mclass_reg;
    assign labels.stopped      = stopped_reg;

    // Checks
    `HWS_ASSERT_SAME(a_bad_magic_stops, clk, rst_n,
        out_vld_reg && kind_reg == KIND_BAD_MAGIC, stopped_reg,
        "bad magic result without stopped flag")
    `HWS_ASSERT_SAME(a_class_only_on_type, clk, rst_n,
        out_vld_reg && mclass_reg != '0, kind_reg == KIND_TYPE,
        "memory class set on a word that is not a type word")
    `HWS_ASSERT_SAME(a_count_nonzero, clk, rst_n,
        phase_reg == PH_HNAME || phase_reg == PH_HSIZE || phase_reg == PH_CODE ||
        phase_reg == PH_ROFF || phase_reg == PH_SNAME,
        remaining_reg != '0, "counting phase entered with zero remaining")
    `HWS_ASSERT_NEXT(a_stop_holds, clk, rst_n,
        in_fire && phase_reg == PH_STOP && !words.restart,
        out_vld_reg && kind_reg == KIND_IGNORED && stopped_reg &&
        phase_reg == PH_STOP, "word after stop not labeled ignored")

endmodule

### tb/hws_label_checker.sv
// Label checker for the hunk word stream parser: watches both channels,
// predicts each label from the accepted words and compares field by field.
// Depends on hws_pkg, hws_in_if and hws_out_if.
`timescale 1ns / 1ps

module hws_label_checker (
    input  logic clk,
    input  logic rst_n,
    hws_in_if    words,
    hws_out_if   labels,
    output int   pending_labels,
    output int   mismatch_count
);
    import hws_pkg::*;

    // One predicted label, at the widths of the output channel.
    typedef struct packed {
        kind_t               kind;
        logic [WORD_W-1:0]   value;
        logic [CODE_W-1:0]   type_code;
        logic [CLASS_W-1:0]  memory_class;
        logic                stopped;
    } label_t;

    label_t            expected_labels[$];
    phase_t            parse_phase;
    logic [WORD_W-1:0] words_left;
    body_t             body_after_flags;
    int                error_total;

    // Phase that starts the body of a hunk.
    function automatic phase_t body_start(input body_t body);
        case (body)
            BODY_CODE:   return PH_CLEN;
            BODY_RELOC:  return PH_RCOUNT;
            BODY_SYMBOL: return PH_SLEN;
            default:     return PH_STOP;
        endcase
    endfunction

    // Labels one word and advances the parser copy by it.
    function automatic label_t label_word(input logic [WORD_W-1:0] w, input logic restart);
        label_t lbl;
        body_t  body;
        lbl.kind         = KIND_IGNORED;
        lbl.value        = w;
        lbl.type_code    = '0;
        lbl.memory_class = '0;
        body             = BODY_NONE;
        if (restart)
        begin
            parse_phase      = PH_MAGIC;
            words_left       = '0;
            body_after_flags = BODY_NONE;
        end
        case (parse_phase)
            PH_MAGIC, PH_TYPE:
            begin
                if (parse_phase == PH_MAGIC && w != MAGIC_WORD)
                begin
                    lbl.kind    = KIND_BAD_MAGIC;
                    parse_phase = PH_STOP;
                end
                else
                begin
                    lbl.kind      = KIND_TYPE;
                    lbl.type_code = w[CODE_W-1:0];
                    // A header type never carries a memory class.
                    if (w[CODE_W-1:0] == T_HEADER)
                        parse_phase = PH_HNLEN;
                    else
                    begin
                        lbl.memory_class = w[WORD_W-1:CODE_W];
                        if (w[CODE_W-1:0] == T_CODE)
                            body = BODY_CODE;
                        else if (w[CODE_W-1:0] == T_RELOC32)
                            body = BODY_RELOC;
                        else if (w[CODE_W-1:0] == T_SYMBOL)
                            body = BODY_SYMBOL;
                        if (w[WORD_W-1:CODE_W] == CLASS_FLAGS)
                        begin
                            body_after_flags = body;
                            parse_phase      = PH_FLAGS;
                        end
                        else
                            parse_phase = body_start(body);
                    end
                end
            end
            PH_FLAGS:
            begin
                lbl.kind         = KIND_FLAGS;
                parse_phase      = body_start(body_after_flags);
                body_after_flags = BODY_NONE;
            end
            PH_HNLEN:
            begin
                lbl.kind    = KIND_HDR_NAME;
                words_left  = w;
                parse_phase = (w != '0) ? PH_HNAME : PH_HTAB;
            end
            PH_HNAME:
            begin
                lbl.kind   = KIND_HDR_NAME;
                words_left = words_left - 1;
                if (words_left == '0)
                    parse_phase = PH_HTAB;
            end
            PH_HTAB:
            begin
                lbl.kind    = KIND_TABLE_LEN;
                words_left  = w;
                parse_phase = PH_HFIRST;
            end
            PH_HFIRST:
            begin
                lbl.kind    = KIND_FIRST;
                parse_phase = PH_HLAST;
            end
            PH_HLAST:
            begin
                lbl.kind    = KIND_LAST;
                parse_phase = (words_left != '0) ? PH_HSIZE : PH_TYPE;
            end
            PH_HSIZE:
            begin
                lbl.kind   = KIND_SIZE;
                words_left = words_left - 1;
                if (words_left == '0)
                    parse_phase = PH_TYPE;
            end
            PH_CLEN:
            begin
                lbl.kind    = KIND_CODE_LEN;
                words_left  = w;
                parse_phase = (w != '0) ? PH_CODE : PH_TYPE;
            end
            PH_CODE:
            begin
                lbl.kind   = KIND_CODE;
                words_left = words_left - 1;
                if (words_left == '0)
                    parse_phase = PH_TYPE;
            end
            PH_RCOUNT:
            begin
                // A zero count closes the reloc32 hunk.
                if (w == '0)
                begin
                    lbl.kind    = KIND_RELOC_END;
                    parse_phase = PH_TYPE;
                end
                else
                begin
                    lbl.kind    = KIND_RELOC_COUNT;
                    words_left  = w;
                    parse_phase = PH_RHUNK;
                end
            end
            PH_RHUNK:
            begin
                lbl.kind    = KIND_RELOC_HUNK;
                parse_phase = PH_ROFF;
            end
            PH_ROFF:
            begin
                lbl.kind   = KIND_RELOC_OFF;
                words_left = words_left - 1;
                if (words_left == '0)
                    parse_phase = PH_RCOUNT;
            end
            PH_SLEN:
            begin
                // A zero length closes the symbol hunk and is labeled the same.
                lbl.kind = KIND_SYM_LEN;
                if (w == '0)
                    parse_phase = PH_TYPE;
                else
                begin
                    words_left  = w;
                    parse_phase = PH_SNAME;
                end
            end
            PH_SNAME:
            begin
                lbl.kind   = KIND_SYM_NAME;
                words_left = words_left - 1;
                if (words_left == '0)
                    parse_phase = PH_SOFF;
            end
            PH_SOFF:
            begin
                lbl.kind    = KIND_SYM_OFF;
                parse_phase = PH_SLEN;
            end
            default:
            begin
                lbl.kind    = KIND_IGNORED;
                parse_phase = PH_STOP;
            end
        endcase
        lbl.stopped = (parse_phase == PH_STOP);
        return lbl;
    endfunction

    // Compare the label leaving the block, then predict the word entering it.
    always @(posedge clk or negedge rst_n)
    begin
        label_t exp_lbl;
        if (!rst_n)
        begin
            parse_phase      = PH_MAGIC;
            words_left       = '0;
            body_after_flags = BODY_NONE;
            expected_labels.delete();
            pending_labels <= 0;
        end
        else
        begin
            if (labels.valid && labels.ready)
            begin
                if (expected_labels.size() == 0)
                begin
                    $error("label: unexpected request, value %h", labels.value);
                    error_total++;
                end
                else
                begin
                    exp_lbl = expected_labels.pop_front();
                    if (labels.kind !== exp_lbl.kind)
                    begin
                        $error("kind: expected %0d, got %0d", exp_lbl.kind, labels.kind);
                        error_total++;
                    end
                    if (labels.value !== exp_lbl.value)
                    begin
                        $error("value: expected %h, got %h", exp_lbl.value, labels.value);
                        error_total++;
                    end
                    if (labels.type_code !== exp_lbl.type_code)
                    begin
                        $error("type_code: expected %h, got %h",
                               exp_lbl.type_code, labels.type_code);
                        error_total++;
                    end
                    if (labels.memory_class !== exp_lbl.memory_class)
                    begin
                        $error("memory_class: expected %0d, got %0d",
                               exp_lbl.memory_class, labels.memory_class);
                        error_total++;
                    end
                    if (labels.stopped !== exp_lbl.stopped)
                    begin
                        $error("stopped: expected %0b, got %0b",
                               exp_lbl.stopped, labels.stopped);
                        error_total++;
                    end
                end
            end
            if (words.valid && words.ready)
                expected_labels.push_back(label_word(words.word, words.restart));
            pending_labels <= expected_labels.size();
        end
        mismatch_count <= error_total;
    end

endmodule

### tb/hunk_word_stream_parser_core_tb.sv
// Testbench top for the hunk word stream parser: drives file words, stalls
// the label receiver, and gives the verdict. Depends on hws_pkg, both channel
// interfaces, hws_label_checker and the block itself.
`timescale 1ns / 1ps

module hunk_word_stream_parser_core_tb;
    import hws_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 240;

    logic clk;
    logic rst_n;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    int   words_sent    = 0;
    int   quiet_cycles  = 0;
    int   hold_left     = 0;
    logic hold_req      = 1'b0;
    logic hold_seen     = 1'b0;
    int   pending_labels;
    int   mismatch_count;

    hws_in_if  words_if ();
    hws_out_if labels_if ();

    hunk_word_stream_parser_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .words  (words_if),
        .labels (labels_if)
    );

    hws_label_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .words          (words_if),
        .labels         (labels_if),
        .pending_labels (pending_labels),
        .mismatch_count (mismatch_count)
    );

    // Clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Label receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            labels_if.ready <= 1'b0;
        else if (hold_req && !hold_seen)
        begin
            hold_seen       <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            labels_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left       <= hold_left - 1;
            labels_if.ready <= 1'b0;
        end
        else
            labels_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if (!rst_n || (words_if.valid && words_if.ready) ||
            (labels_if.valid && labels_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("hunk_word_stream_parser_core_tb: done, errors");
            $finish;
        end
    end

    // Offers one word and waits until the block takes it.
    task automatic send(input logic [WORD_W-1:0] w, input logic restart);
        while ($urandom_range(99) < src_idle_pct)
        begin
            words_if.valid <= 1'b0;
            @(posedge clk);
        end
        words_if.valid   <= 1'b1;
        words_if.word    <= w;
        words_if.restart <= restart;
        @(posedge clk);
        while (!words_if.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Type word with a random memory class, and its flags word if one follows.
    task automatic send_type(input logic [CODE_W-1:0] code);
        logic [CLASS_W-1:0] cls;
        cls = CLASS_W'($urandom_range(3));
        send({cls, code}, 1'b0);
        if (cls == CLASS_FLAGS && code != T_HEADER)
            send($urandom, 1'b0);
    endtask

    // Header body: name, table length, first, last and the size words.
    task automatic send_header_body();
        int n_name;
        int n_size;
        n_name = $urandom_range(0, 3);
        n_size = $urandom_range(0, 4);
        send(n_name, 1'b0);
        repeat (n_name) send($urandom, 1'b0);
        send(n_size, 1'b0);
        send($urandom, 1'b0);
        send($urandom, 1'b0);
        repeat (n_size) send($urandom, 1'b0);
    endtask

    task automatic send_code_body();
        int n_code;
        n_code = $urandom_range(0, 6);
        send(n_code, 1'b0);
        repeat (n_code) send($urandom, 1'b0);
    endtask

    // Reloc32 groups of count, hunk id and offsets, closed by a zero count.
    task automatic send_reloc_body();
        int n_offs;
        repeat ($urandom_range(0, 3))
        begin
            n_offs = $urandom_range(1, 4);
            send(n_offs, 1'b0);
            send($urandom, 1'b0);
            repeat (n_offs) send($urandom, 1'b0);
        end
        send('0, 1'b0);
    endtask

    // Symbol entries of length, name words and offset, closed by a zero length.
    task automatic send_symbol_body();
        int n_name;
        repeat ($urandom_range(0, 3))
        begin
            n_name = $urandom_range(1, 3);
            send(n_name, 1'b0);
            repeat (n_name) send($urandom, 1'b0);
            send($urandom, 1'b0);
        end
        send('0, 1'b0);
    endtask

    // A well-formed file: header hunk, then a few hunks, maybe ending on an
    // unhandled type followed by ignored words.
    task automatic send_file();
        int pick;
        send(MAGIC_WORD, ($urandom_range(9) != 0));
        send_header_body();
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                send_type(T_CODE);
                send_code_body();
            end
            else if (pick < 60)
            begin
                send_type(T_RELOC32);
                send_reloc_body();
            end
            else if (pick < 85)
            begin
                send_type(T_SYMBOL);
                send_symbol_body();
            end
            else if (pick < 93)
            begin
                send_type(T_HEADER);
                send_header_body();
            end
            else
            begin
                send_type(CODE_W'($urandom));
                repeat ($urandom_range(0, 3)) send($urandom, 1'b0);
                return;
            end
        end
    endtask

    // A file cut short inside a body with a huge count; it begins with a restart.
    task automatic send_cut_file();
        int pick;
        send(MAGIC_WORD, 1'b1);
        pick = $urandom_range(3);
        if (pick == 0)
            send($urandom, 1'b0);
        else
        begin
            send_header_body();
            send_type((pick == 1) ? T_CODE : (pick == 2) ? T_RELOC32 : T_SYMBOL);
            send($urandom | 32'h1, 1'b0);
        end
        repeat ($urandom_range(1, 5)) send($urandom, 1'b0);
    endtask

    // Random part up to a running word total.
    task automatic run_random(input int target);
        int pick;
        while (words_sent < target)
        begin
            if (!hold_req && words_sent >= 250)
                hold_req <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 75)
                send_file();
            else if (pick < 87)
                send_cut_file();
            else
                repeat ($urandom_range(1, 8)) send($urandom, ($urandom_range(9) == 0));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n             = 1'b0;
        words_if.valid    = 1'b0;
        words_if.word     = '0;
        words_if.restart  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: magic with class bits set is still bad magic, then ignored.
        src_idle_pct  = 21;
        sink_idle_pct = 45;
        send({2'd1, T_HEADER}, 1'b1);
        send(32'hffff_ffff, 1'b0);
        // Header with one name word and one size word at the extremes.
        send(MAGIC_WORD, 1'b1);
        send(32'd1, 1'b0);
        send(32'hffff_ffff, 1'b0);
        send(32'd1, 1'b0);
        send(32'h0, 1'b0);
        send(32'h0, 1'b0);
        send(32'hffff_ffff, 1'b0);
        // Code hunk with flags word and empty body.
        send({CLASS_FLAGS, T_CODE}, 1'b0);
        send(32'hffff_ffff, 1'b0);
        send(32'h0, 1'b0);
        // Reloc32 hunk with one offset.
        send({2'd1, T_RELOC32}, 1'b0);
        send(32'd1, 1'b0);
        send(32'h0, 1'b0);
        send(32'hffff_ffff, 1'b0);
        send(32'h0, 1'b0);
        // Symbol hunk with one entry.
        send({2'd2, T_SYMBOL}, 1'b0);
        send(32'd1, 1'b0);
        send(32'h5555_aaaa, 1'b0);
        send(32'haaaa_5555, 1'b0);
        send(32'h0, 1'b0);
        // Header type with class bits set: no flags word, empty name and table.
        send({CLASS_FLAGS, T_HEADER}, 1'b0);
        send(32'h0, 1'b0);
        send(32'h0, 1'b0);
        send(32'h1, 1'b0);
        send(32'h1, 1'b0);
        // Unhandled type with flags word: the flags word is still consumed.
        send({CLASS_FLAGS, 30'h3fff_ffff}, 1'b0);
        send(32'h0, 1'b0);
        send(32'h1234_5678, 1'b0);

        // Random phases with different idling on each side.
        run_random(550);
        src_idle_pct  = 45;
        sink_idle_pct = 21;
        run_random(1100);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(1650);
        words_if.valid <= 1'b0;

        // Drain outstanding labels, then let the pipeline settle.
        @(posedge clk);
        while (pending_labels != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("hunk_word_stream_parser_core_tb: done, clean");
        else
            $display("hunk_word_stream_parser_core_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/hws_pkg.sv
sv/hws_in_if.sv
sv/hws_out_if.sv
sv/hunk_word_stream_parser_core.sv
tb/hws_label_checker.sv
tb/hunk_word_stream_parser_core_tb.sv
